/* sv/mf_pkg.sv */
// ----------------------------------------------------------------------------
// mf_pkg
// Types and constants shared by the 3x3 median filter modules.
// ----------------------------------------------------------------------------
package mf_pkg;

	localparam int MAX_HEIGHT   = 1024;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 11;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} mf_in_item_t;

	typedef struct packed {
		logic [7:0] filtered;
		logic [9:0] out_row;
		logic [9:0] out_col;
	} mf_out_item_t;

	// position and border status of one emitted pixel
	typedef struct packed {
		logic       interior;
		logic [9:0] row;
		logic [9:0] col;
	} mf_meta_t;

	// window entry r*3+c: r = 0 oldest row, c = 2 newest column
	typedef logic [8:0][7:0] mf_win_t;

endpackage

/* sv/mf_ram.sv */
// ----------------------------------------------------------------------------
// mf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/mf_median.sv */
// ----------------------------------------------------------------------------
// mf_median
// Three-stage median-of-nine network: column sort, min/med/max, final median.
// ----------------------------------------------------------------------------
module mf_median import mf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         win_valid,
	input  mf_win_t      win,
	input  mf_meta_t     meta,
	output logic         res_valid,
	output mf_out_item_t res
);

	function automatic logic [2:0][7:0] sort3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] x, y, z, t;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		return {z, y, x};
	endfunction

	function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [2:0][7:0] s;
		s = sort3(a, b, c);
		return s[1];
	endfunction

	logic [2:0][2:0][7:0] cols_s1;
	logic                 v_s1;
	mf_meta_t             meta_s1;
	logic [7:0]           lo_s2, mid_s2, hi_s2;
	logic                 v_s2;
	mf_meta_t             meta_s2;
	logic                 v_s3;
	mf_out_item_t         res_s3;

	logic [7:0] lo, hi;

	always_comb begin
		lo = cols_s1[0][0];
		if (cols_s1[1][0] > lo) lo = cols_s1[1][0];
		if (cols_s1[2][0] > lo) lo = cols_s1[2][0];
		hi = cols_s1[0][2];
		if (cols_s1[1][2] < hi) hi = cols_s1[1][2];
		if (cols_s1[2][2] < hi) hi = cols_s1[2][2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= win_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				cols_s1[c] <= sort3(win[c], win[3 + c], win[6 + c]);
			end
			meta_s1 <= meta;
			lo_s2   <= lo;
			mid_s2  <= med3(cols_s1[0][1], cols_s1[1][1], cols_s1[2][1]);
			hi_s2   <= hi;
			meta_s2 <= meta_s1;
			res_s3.filtered <= meta_s2.interior ? med3(lo_s2, mid_s2, hi_s2) : 8'd0;
			res_s3.out_row  <= meta_s2.row;
			res_s3.out_col  <= meta_s2.col;
		end
	end

	assign res_valid = en && v_s3;
	assign res       = res_s3;

endmodule

/* sv/mf_skid.sv */
// ----------------------------------------------------------------------------
// mf_skid
// Two-entry output buffer; full freezes the pipeline in front of it.
// ----------------------------------------------------------------------------
module mf_skid import mf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mf_out_item_t push_item,
	output logic         full,
	output logic         valid,
	input  logic         stall,
	output mf_out_item_t item
);

	logic [1:0]   count_q;
	mf_out_item_t e0_q, e1_q;
	logic         pop;

	assign pop   = valid && !stall;
	assign valid = count_q != 2'd0;
	assign full  = count_q == 2'd2;
	assign item  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) e0_q <= push_item;
				else e1_q <= push_item;
			end
			2'b01: e0_q <= e1_q;
			2'b11: begin
				if (count_q == 2'd1) begin
					e0_q <= push_item;
				end else begin
					e0_q <= e1_q;
					e1_q <= push_item;
				end
			end
			default: e0_q <= e0_q;
		endcase
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2)
		else $error("push into full output buffer");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && stall |=> full && $stable(item))
		else $error("stalled output buffer changed");

endmodule

/* sv/median_filter_3x3.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grey images in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the px channel (px_valid, px_stall, px_item), results leave
// on the med channel (med_valid, med_stall, med_item) with their row and
// column. Each pixel at row r >= 1, column c >= 1 yields the result for
// (r-1, c-1); border results are zero and the last row and column are not
// sent. frame_start forces the pixel to position 0,0.
// Throughput: one pixel per cycle while px_stall is low. Each pixel reads and
// writes the combined line store entry of its column once; the write-back of
// one pixel and the read of the next share a cycle, with forwarding when the
// column repeats. The pixel that completes a window passes the line store
// stage, the window shift, three median stages and the output buffer before
// its result raises med_valid. When med_stall holds the two-entry output
// buffer full, px_stall rises and the whole pipeline holds. Reset clears
// position, window and valid flags and sets width 640, height 480; the line
// store content is undefined until written. Configuration (cfg_*) must be
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  px_valid,
	output logic                  px_stall,
	input  mf_in_item_t           px_item,
	output logic                  med_valid,
	input  logic                  med_stall,
	output mf_out_item_t          med_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WCW  = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
		: CFG_DATA_W;
	localparam int OW   = (CW > 10) ? CW : 10;

	logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
	logic [9:0]            in_row_q;
	logic [CW-1:0]         in_col_q;

	logic [WCW-1:0]        w_raw, w_eff;
	logic [CFG_DATA_W-1:0] h_eff;
	logic [9:0]            pos_row;
	logic [CW-1:0]         pos_col;
	logic [CW:0]           col_p1;
	logic [CFG_DATA_W-1:0] row_p1;
	logic [CW-1:0]         col_m1;
	logic [OW-1:0]         ocol_ext;
	logic                  emit, interior;

	logic                  en, acc;
	logic                  skid_full;

	logic                  v_s1, emit_s1;
	logic [7:0]            px_s1;
	logic [CW-1:0]         col_s1;
	mf_meta_t              meta_s1;

	logic                  fwd_q;
	logic [15:0]           fwd_data_q;
	logic [15:0]           rd_data, line_data;
	logic [7:0]            up1, up2;
	logic                  wr_en;
	logic [15:0]           wr_data;

	mf_win_t               win_q;
	logic                  v_s2;
	mf_meta_t              meta_s2;

	logic                  res_valid;
	mf_out_item_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DATA_W'(WIDTH_RESET);
			frame_height_q <= CFG_DATA_W'(HEIGHT_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: frame_width_q <= frame_width_q;
			endcase
		end
	end

	// clamp limits
	always_comb begin
		w_raw = WCW'(frame_width_q);
		if (w_raw < WCW'(3)) w_eff = WCW'(3);
		else if (w_raw > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
		else w_eff = w_raw;
		if (frame_height_q < CFG_DATA_W'(3)) h_eff = CFG_DATA_W'(3);
		else if (frame_height_q > CFG_DATA_W'(MAX_HEIGHT)) h_eff = CFG_DATA_W'(MAX_HEIGHT);
		else h_eff = frame_height_q;
	end

	assign en       = !skid_full;
	assign px_stall = !en;
	assign acc      = px_valid && en;

	assign pos_row  = px_item.frame_start ? 10'd0 : in_row_q;
	assign pos_col  = px_item.frame_start ? '0 : in_col_q;
	assign col_p1   = {1'b0, pos_col} + (CW + 1)'(1);
	assign row_p1   = {1'b0, pos_row} + CFG_DATA_W'(1);
	assign col_m1   = pos_col - CW'(1);
	assign ocol_ext = OW'(col_m1);
	assign emit     = (pos_row != 10'd0) && (pos_col != '0);
	assign interior = (pos_row >= 10'd2) && (pos_col >= CW'(2))
		&& (row_p1 <= h_eff) && (WCW'(col_p1) <= w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= 10'd0;
			in_col_q <= '0;
		end else if (acc) begin
			if (WCW'(col_p1) >= w_eff) begin
				in_col_q <= '0;
				in_row_q <= (row_p1 >= h_eff) ? 10'd0 : row_p1[9:0];
			end else begin
				in_col_q <= col_p1[CW-1:0];
				in_row_q <= pos_row;
			end
		end
	end

	// line store entry: [15:8] previous row, [7:0] row before that
	assign wr_en     = en && v_s1;
	assign line_data = fwd_q ? fwd_data_q : rd_data;
	assign up1       = line_data[15:8];
	assign up2       = line_data[7:0];
	assign wr_data   = {px_s1, up1};

	mf_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (wr_data),
		.rd_en   (acc),
		.rd_addr (pos_col),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
			v_s2  <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			if (acc) fwd_q <= wr_en && (col_s1 == pos_col);
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1          <= px_item.pixel;
			col_s1         <= pos_col;
			emit_s1        <= emit;
			meta_s1.interior <= interior;
			meta_s1.row    <= pos_row - 10'd1;
			meta_s1.col    <= ocol_ext[9:0];
			fwd_data_q     <= wr_data;
		end
		if (en) begin
			meta_s2 <= meta_s1;
		end
	end

	// shift window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= up2;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= up1;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	mf_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.win_valid (v_s2),
		.win       (win_q),
		.meta      (meta_s2),
		.res_valid (res_valid),
		.res       (res)
	);

	mf_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res),
		.full      (skid_full),
		.valid     (med_valid),
		.stall     (med_stall),
		.item      (med_item)
	);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		px_stall |-> med_valid)
		else $error("input held while no result is waiting");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en |=> v_s1 && $stable(col_s1) && $stable(px_s1))
		else $error("line store stage moved while frozen");

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		acc && wr_en && (col_s1 == pos_col) |=> fwd_q)
		else $error("missed forwarding of line store write");

endmodule

/* sim/median_filter_3x3_tb.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3_tb
// Self-checking bench for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
// Pixel images are streamed through the block under random idling on both
// channels. A behavioural copy of the filter, with its own line stores,
// window and position counters, predicts every result. The monitor compares
// each result, field by field, with the oldest prediction. Geometry is
// changed only while the block is idle: at reset values, tiny directed
// images, clamped extremes, changes in the middle of an image, random
// phases, and a final stretch without idling.
// ----------------------------------------------------------------------------
module median_filter_3x3_tb;
	import mf_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int MAX_PRINTS    = 30;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);

	localparam int PIX_FULL = 0;
	localparam int PIX_BILEVEL = 1;
	localparam int PIX_NARROW = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  px_valid;
	logic                  px_stall;
	mf_in_item_t           px_item;
	logic                  med_valid;
	logic                  med_stall;
	mf_out_item_t          med_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [10:0]  frame_width_q;
	logic [10:0]  frame_height_q;
	logic [7:0]   prev_line [MAX_W];
	logic [7:0]   prev2_line [MAX_W];
	mf_win_t      window_q;
	int unsigned  row_pos;
	int unsigned  col_pos;
	mf_out_item_t pending_medians [$];

	int err_count;
	bit idle_en;
	int stall_left;

	median_filter_3x3 #(
		.MAX_WIDTH(MAX_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.px_valid (px_valid),
		.px_stall (px_stall),
		.px_item  (px_item),
		.med_valid(med_valid),
		.med_stall(med_stall),
		.med_item (med_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < MAX_PRINTS)
			$display("mismatch %s: got %0d, want %0d", what, got, want);
		err_count++;
	endtask

	function automatic logic [7:0] median_of_nine(input mf_win_t w);
		int i;
		int j;
		int below;
		int not_above;
		for (i = 0; i < 9; i++) begin
			below = 0;
			not_above = 0;
			for (j = 0; j < 9; j++) begin
				if (w[j] < w[i])
					below++;
				if (w[j] <= w[i])
					not_above++;
			end
			if (below <= 4 && not_above >= 5)
				return w[i];
		end
		return 8'h00;
	endfunction

	function automatic void predict_pixel(input mf_in_item_t it);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned orow;
		int unsigned ocol;
		logic [7:0] up1;
		logic [7:0] up2;
		mf_out_item_t res;
		w = (frame_width_q < 3) ? 3 : ((frame_width_q > MAX_W) ? MAX_W : frame_width_q);
		h = (frame_height_q < 3) ? 3 :
			((frame_height_q > MAX_HEIGHT) ? MAX_HEIGHT : frame_height_q);
		if (it.frame_start) begin
			row_pos = 0;
			col_pos = 0;
		end
		col = col_pos % MAX_W;
		up1 = prev_line[col];
		up2 = prev2_line[col];
		prev2_line[col] = up1;
		prev_line[col] = it.pixel;
		window_q[0] = window_q[1]; window_q[1] = window_q[2]; window_q[2] = up2;
		window_q[3] = window_q[4]; window_q[4] = window_q[5]; window_q[5] = up1;
		window_q[6] = window_q[7]; window_q[7] = window_q[8]; window_q[8] = it.pixel;
		if (row_pos >= 1 && col_pos >= 1) begin
			orow = row_pos - 1;
			ocol = col_pos - 1;
			res.filtered = 8'h00;
			if (orow >= 1 && ocol >= 1 && orow + 2 <= h && ocol + 2 <= w)
				res.filtered = median_of_nine(window_q);
			res.out_row = orow[9:0];
			res.out_col = ocol[9:0];
			pending_medians = {pending_medians, res};
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function automatic logic [7:0] next_pixel(input int mode);
		case (mode)
			PIX_BILEVEL: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			PIX_NARROW: return 8'($urandom_range(100, 103));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] pix, input logic fs);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			px_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		px_valid <= 1'b1;
		px_item <= '{pixel: pix, frame_start: fs};
		do @(posedge clk); while (px_stall);
		predict_pixel('{pixel: pix, frame_start: fs});
	endtask

	task automatic send_run(input int count, input int mode, input bit first_fs,
			input bit fs_noise);
		int n;
		logic fs;
		for (n = 0; n < count; n++) begin
			fs = (n == 0) ? first_fs : (fs_noise && $urandom_range(0, 63) == 0);
			send_pixel(next_pixel(mode), fs);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_WIDTH)
			frame_width_q = data;
		else if (idx == REG_FRAME_HEIGHT)
			frame_height_q = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		int waited;
		waited = 0;
		@(negedge clk);
		px_valid <= 1'b0;
		while (pending_medians.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_medians.size() != 0) begin
			report_mismatch("results still pending", 0, pending_medians.size());
			pending_medians.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		med_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 5);
			med_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		mf_out_item_t want;
		if (arst_n && med_valid && !med_stall) begin
			if (pending_medians.size() == 0) begin
				report_mismatch("result with nothing pending, row", med_item.out_row, -1);
			end else begin
				want = pending_medians.pop_front();
				if (med_item.filtered !== want.filtered)
					report_mismatch("filtered", med_item.filtered, want.filtered);
				if (med_item.out_row !== want.out_row)
					report_mismatch("out_row", med_item.out_row, want.out_row);
				if (med_item.out_col !== want.out_col)
					report_mismatch("out_col", med_item.out_col, want.out_col);
			end
		end
	end

	task automatic test_reset_geometry;
		send_run(645, PIX_FULL, 1'b0, 1'b0);
		drain();
	endtask

	task automatic test_tiny_images;
		logic [7:0] mixed [9];
		int n;
		mixed = '{8'h00, 8'hFF, 8'h07, 8'hC8, 8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE};
		write_reg(REG_FRAME_WIDTH, 11'd0);
		write_reg(REG_FRAME_HEIGHT, 11'd2);
		for (n = 0; n < 9; n++)
			send_pixel(8'hFF, n == 0);
		for (n = 0; n < 4; n++)
			send_pixel(next_pixel(PIX_FULL), 1'b0);
		for (n = 0; n < 9; n++)
			send_pixel(mixed[n], n == 0);
		drain();
	endtask

	task automatic test_register_clamp;
		write_reg(REG_FRAME_WIDTH, 11'h7FF);
		write_reg(REG_FRAME_HEIGHT, 11'd3);
		write_reg(REG_SPARE, 11'($urandom));
		send_run(1030, PIX_FULL, 1'b1, 1'b0);
		drain();
		write_reg(REG_FRAME_WIDTH, 11'd6);
		write_reg(REG_FRAME_HEIGHT, 11'd0);
		send_run(20, PIX_NARROW, 1'b1, 1'b0);
		drain();
		write_reg(REG_FRAME_WIDTH, 11'd5);
		write_reg(REG_FRAME_HEIGHT, 11'h7FF);
		send_run(20, PIX_BILEVEL, 1'b1, 1'b0);
		drain();
	endtask

	task automatic test_mid_image_change;
		write_reg(REG_FRAME_WIDTH, 11'd12);
		write_reg(REG_FRAME_HEIGHT, 11'd7);
		send_run(30, PIX_FULL, 1'b1, 1'b0);
		drain();
		// narrow the row and deepen the image without restarting it
		write_reg(REG_FRAME_WIDTH, 11'd5);
		write_reg(REG_FRAME_HEIGHT, 11'd9);
		send_run(40, PIX_FULL, 1'b0, 1'b0);
		drain();
		write_reg(REG_FRAME_HEIGHT, 11'd4);
		send_run(20, PIX_FULL, 1'b0, 1'b0);
		drain();
	endtask

	task automatic test_random_phases(input int count);
		int sent;
		int len;
		logic [10:0] w;
		logic [10:0] h;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0: w = 11'($urandom_range(0, 2));
				1: w = 11'($urandom_range(17, 64));
				2: w = 11'($urandom_range(1025, 2047));
				default: w = 11'($urandom_range(3, 16));
			endcase
			case ($urandom_range(0, 9))
				0: h = 11'($urandom_range(0, 2));
				1: h = 11'($urandom_range(1025, 2047));
				2: h = 11'($urandom_range(11, 40));
				default: h = 11'($urandom_range(3, 10));
			endcase
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			len = $urandom_range(30, 60);
			send_run(len, $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : PIX_FULL,
				1'b1, 1'b1);
			drain();
			sent += len;
		end
	endtask

	task automatic test_steady_stream;
		idle_en = 1'b0;
		write_reg(REG_FRAME_WIDTH, 11'd8);
		write_reg(REG_FRAME_HEIGHT, 11'd6);
		send_run(80, PIX_FULL, 1'b1, 1'b1);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		px_valid = 1'b0;
		px_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_width_q = 11'(WIDTH_RESET);
		frame_height_q = 11'(HEIGHT_RESET);
		window_q = '0;
		row_pos = 0;
		col_pos = 0;
		err_count = 0;
		idle_en = 1'b1;
		for (int i = 0; i < MAX_W; i++) begin
			prev_line[i] = 8'h00;
			prev2_line[i] = 8'h00;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_tiny_images();
		test_register_clamp();
		test_mid_image_change();
		test_random_phases(60);
		test_steady_stream();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
